// ===== src/tsdq_pkg.sv =====
`default_nettype none

package tsdq_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 48;
    localparam int WAIT_BITS_DEF = 32;

    localparam int SLOT_W      = 4;
    localparam int WAIT_W      = 32;
    localparam int FIRE_TIME_W = 48;

    // expiries emitted per tick at most
    localparam int MAX_FIRE   = 16;
    localparam int FIRE_CNT_W = 5;

    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_STOP = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [WAIT_W-1:0] wait_req;
        logic              no_expiry;
        logic              only_if_sooner;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0]      fired_slot;
        logic [FIRE_TIME_W-1:0] fire_time;
        logic                   last;
    } result_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

endpackage

`default_nettype wire

// ===== src/tsdq_cmp.sv =====
`default_nettype none

// shared magnitude comparator: a against b
module tsdq_cmp #(
    parameter int W = tsdq_pkg::TIME_BITS_DEF
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output tsdq_pkg::cmp_t    flags
);
    import tsdq_pkg::*;

    always_comb
    begin
        flags.lt = a < b;
        flags.eq = a == b;
    end

endmodule

`default_nettype wire

// ===== src/timer_slot_deadline_queue.sv =====
`default_nettype none

// Timer slot deadline queue. Items enter on start while busy is low; results leave on fire,
// one cycle each, and cannot be held off. A stop, a set without expiry, or an undefined op
// is done in the accept cycle and leaves busy low. A set with expiry does the saturating
// deadline add and the read of the old deadline on accept, then in ST_SET one compare on
// the shared comparator and the write. A tick scans the deadline memory through its single
// read port with one comparator, one slot a cycle; each pass picks the next expiry. A tick
// ends after the pass that finds none, or once sixteen have fired; its results come out
// one per pass, earliest deadline first, the last one flagged.
module timer_slot_deadline_queue #(
    parameter int SLOTS     = tsdq_pkg::SLOTS_DEF,
    parameter int TIME_BITS = tsdq_pkg::TIME_BITS_DEF,
    parameter int WAIT_BITS = tsdq_pkg::WAIT_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire tsdq_pkg::cmd_t    cmd,
    output logic                   busy,
    output logic                   fire,
    output tsdq_pkg::result_t      result
);
    import tsdq_pkg::*;

    localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SUM_W  = ((TIME_BITS > WAIT_W) ? TIME_BITS : WAIT_W) + 1;
    localparam logic [WAIT_W-1:0] WAIT_MASK =
        (WAIT_BITS >= WAIT_W) ? {WAIT_W{1'b1}} : WAIT_W'((64'd1 << WAIT_BITS) - 64'd1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SET   = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_PEND  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [TIME_BITS-1:0]    now_reg, now_next;
    logic [SLOTS-1:0]        armed_reg, armed_next;
    logic [TIME_BITS-1:0]    dl_reg, dl_next;
    logic [SIDX_W-1:0]       set_idx_reg, set_idx_next;
    logic                    sooner_reg, sooner_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [SIDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                    found_reg, found_next;
    logic [SIDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [TIME_BITS-1:0]    best_dl_reg, best_dl_next;
    logic                    pend_reg, pend_next;
    logic [SIDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic [FIRE_CNT_W-1:0]   sel_cnt_reg, sel_cnt_next;
    logic                    fire_reg, fire_next;
    result_t                 result_reg, result_next;

    logic [TIME_BITS-1:0]    dl_mem [SLOTS];
    logic [TIME_BITS-1:0]    rd_data_reg;
    logic [SIDX_W-1:0]       rd_addr;
    logic                    mem_we;

    logic                    accept;
    logic                    in_range;
    logic [SIDX_W+SLOT_W-1:0] in_idx_ext;
    logic [SIDX_W-1:0]       in_idx;
    logic [SUM_W-1:0]        sum;
    logic [TIME_BITS-1:0]    sat_dl;
    logic [TIME_BITS-1:0]    cmp_b;
    cmp_t                    cmp_flags;
    logic                    hit;
    logic [SIDX_W+SLOT_W-1:0] pend_slot_ext;
    logic [FIRE_TIME_W+TIME_BITS-1:0] ft_ext;

    assign busy   = state_reg != ST_IDLE;
    assign accept = start && !busy;
    assign fire   = fire_reg;
    assign result = result_reg;

    assign in_range   = 32'(cmd.slot) < SLOTS;
    assign in_idx_ext = {{SIDX_W{1'b0}}, cmd.slot};
    assign in_idx     = in_idx_ext[SIDX_W-1:0];

    assign sum    = SUM_W'(now_reg) + SUM_W'(cmd.wait_req & WAIT_MASK);
    assign sat_dl = (|(sum >> TIME_BITS)) ? TIME_MAX : sum[TIME_BITS-1:0];

    assign pend_slot_ext = {{SLOT_W{1'b0}}, pend_idx_reg};
    assign ft_ext        = {{FIRE_TIME_W{1'b0}}, now_reg};

    assign cmp_b = (state_reg == ST_SET) ? dl_reg : (found_reg ? best_dl_reg : now_reg);

    tsdq_cmp #(
        .W (TIME_BITS)
    ) u_cmp (
        .a     (rd_data_reg),
        .b     (cmp_b),
        .flags (cmp_flags)
    );

    // first hit is due (at or before now), later ones must beat the best so far
    assign hit = found_reg ? cmp_flags.lt : (cmp_flags.lt || cmp_flags.eq);

    always_comb
    begin
        state_next    = state_reg;
        now_next      = now_reg;
        armed_next    = armed_reg;
        dl_next       = dl_reg;
        set_idx_next  = set_idx_reg;
        sooner_next   = sooner_reg;
        cnt_next      = cnt_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cnt_reg[SIDX_W-1:0];
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_dl_next  = best_dl_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        sel_cnt_next  = sel_cnt_reg;
        fire_next     = 1'b0;
        result_next   = result_reg;
        rd_addr       = set_idx_reg;
        mem_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = in_idx;
                if (accept)
                begin
                    unique case (cmd.op)
                        OP_SET:
                        begin
                            if (in_range)
                            begin
                                if (cmd.no_expiry)
                                begin
                                    if (!cmd.only_if_sooner)
                                        armed_next[in_idx] = 1'b0;
                                end
                                else
                                begin
                                    dl_next      = sat_dl;
                                    set_idx_next = in_idx;
                                    sooner_next  = cmd.only_if_sooner;
                                    state_next   = ST_SET;
                                end
                            end
                        end
                        OP_STOP:
                        begin
                            if (in_range)
                                armed_next[in_idx] = 1'b0;
                        end
                        OP_TICK:
                        begin
                            if (now_reg != TIME_MAX)
                                now_next = now_reg + TIME_BITS'(1);
                            cnt_next     = '0;
                            found_next   = 1'b0;
                            pend_next    = 1'b0;
                            sel_cnt_next = '0;
                            state_next   = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SET:
            begin
                // old deadline at or below new one blocks a sooner-only set
                if (!(sooner_reg && armed_reg[set_idx_reg]
                      && (cmp_flags.lt || cmp_flags.eq)))
                begin
                    mem_we                  = 1'b1;
                    armed_next[set_idx_reg] = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                rd_addr = cnt_reg[SIDX_W-1:0];
                if (cnt_reg < CNT_W'(SLOTS))
                begin
                    cmp_vld_next = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    if (armed_reg[cmp_idx_reg] && hit)
                    begin
                        found_next    = 1'b1;
                        best_idx_next = cmp_idx_reg;
                        best_dl_next  = rd_data_reg;
                    end
                    if (cmp_idx_reg == SIDX_W'(SLOTS - 1))
                        state_next = ST_PEND;
                end
            end
            ST_PEND:
            begin
                fire_next              = pend_reg;
                result_next.fired_slot = pend_slot_ext[SLOT_W-1:0];
                result_next.fire_time  = ft_ext[FIRE_TIME_W-1:0];
                result_next.last       = !found_reg;
                if (found_reg)
                begin
                    armed_next[best_idx_reg] = 1'b0;
                    pend_next                = 1'b1;
                    pend_idx_next            = best_idx_reg;
                    sel_cnt_next             = sel_cnt_reg + FIRE_CNT_W'(1);
                    cnt_next                 = '0;
                    found_next               = 1'b0;
                    if (sel_cnt_next == FIRE_CNT_W'(MAX_FIRE))
                        state_next = ST_FLUSH;
                    else
                        state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                fire_next              = 1'b1;
                result_next.fired_slot = pend_slot_ext[SLOT_W-1:0];
                result_next.fire_time  = ft_ext[FIRE_TIME_W-1:0];
                result_next.last       = 1'b1;
                state_next             = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            dl_mem[set_idx_reg] <= dl_reg;
        rd_data_reg <= dl_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            now_reg     <= '0;
            armed_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            sel_cnt_reg <= '0;
            cnt_reg     <= '0;
            fire_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            now_reg     <= now_next;
            armed_reg   <= armed_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg   <= found_next;
            pend_reg    <= pend_next;
            sel_cnt_reg <= sel_cnt_next;
            cnt_reg     <= cnt_next;
            fire_reg    <= fire_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg       <= dl_next;
        set_idx_reg  <= set_idx_next;
        sooner_reg   <= sooner_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_dl_reg  <= best_dl_next;
        pend_idx_reg <= pend_idx_next;
        result_reg   <= result_next;
    end

    a_fire_from_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> ($past(state_reg) == ST_PEND || $past(state_reg) == ST_FLUSH))
        else $error("result outside pass end");

    a_last_closes_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.last) |=> !fire)
        else $error("result after last");

    a_fired_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !armed_reg[pend_idx_reg])
        else $error("fired slot still armed");

    a_sel_cap: assert property (@(posedge clk) disable iff (!rst_n)
        sel_cnt_reg <= FIRE_CNT_W'(MAX_FIRE))
        else $error("too many expiries in one tick");

    a_set_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SET) |-> !fire)
        else $error("result during set");

endmodule

`default_nettype wire
